>>> rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types and constants of the line follower PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

	typedef enum logic [1:0] {
		ACT_STEER = 2'd0,
		ACT_CROSS = 2'd1,
		ACT_STOP  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_GAIN_P  = 3'd0,
		REG_GAIN_I  = 3'd1,
		REG_GAIN_D  = 3'd2,
		REG_CRUISE  = 3'd3,
		REG_TRIM    = 3'd4,
		REG_TARGET  = 3'd5
	} reg_idx_t;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0]       GAIN_P_RST = 16'd10240;
	localparam logic [15:0]       GAIN_I_RST = 16'd0;
	localparam logic [15:0]       GAIN_D_RST = 16'd7680;
	localparam logic [7:0]        CRUISE_RST = 8'd120;
	localparam logic signed [6:0] TRIM_RST   = 7'sd20;
	localparam logic [7:0]        TARGET_RST = 8'd1;

	localparam logic [7:0]        FORWARD_SPEED = 8'd150;
	localparam logic signed [8:0] SUM_LIMIT     = 9'sd100;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [15:0]       gain_p;
		logic [15:0]       gain_i;
		logic [15:0]       gain_d;
		logic [7:0]        cruise;
		logic signed [6:0] trim;
		logic [7:0]        target;
	} cfg_t;

	// one classified sample on its way from front to back
	typedef struct packed {
		action_t           action;
		logic [7:0]        crossings;
		logic signed [1:0] err;
		logic signed [7:0] esum;
		logic signed [2:0] deriv;
	} job_t;

endpackage

>>> rtl/lfps_front.sv
// ----------------------------------------------------------------------------
// lfps_front
// Takes sensor samples, tracks crossings and the PID state, classifies each
// sample into a job for the back end.
// ----------------------------------------------------------------------------
module lfps_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        target,
	input  logic              in_valid,
	input  logic [3:0]        sense,     // left_end, mid_left, mid_right, right_end
	input  logic              q_ready,
	output logic              push,
	output lfps_pkg::job_t    job
);

	localparam logic signed [8:0] SUM_LIMIT_P = lfps_pkg::SUM_LIMIT;

	logic              latched_q;
	logic [7:0]        count_q;
	logic signed [7:0] esum_q;
	logic signed [1:0] prev_q;

	logic              trig;
	logic [7:0]        count_inc;
	logic signed [1:0] err;
	logic signed [8:0] esum_raw;
	logic signed [7:0] esum_new;
	logic signed [2:0] deriv;

	assign push = in_valid & q_ready;

	always_comb begin
		trig      = (sense[0] | sense[3]) & ~latched_q;
		count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
		if (sense[1] && !sense[2]) begin
			err = -2'sd1;
		end else if (!sense[1] && sense[2]) begin
			err = 2'sd1;
		end else begin
			err = 2'sd0;
		end
		esum_raw = 9'(esum_q) + 9'(err);
		if (esum_raw > SUM_LIMIT_P) begin
			esum_new = 8'(SUM_LIMIT_P);
		end else if (esum_raw < -SUM_LIMIT_P) begin
			esum_new = 8'(-SUM_LIMIT_P);
		end else begin
			esum_new = esum_raw[7:0];
		end
		deriv = 3'(err) - 3'(prev_q);

		job.crossings = trig ? count_inc : count_q;
		if (trig) begin
			job.action = (count_inc >= target) ? lfps_pkg::ACT_STOP : lfps_pkg::ACT_CROSS;
			job.err    = 2'sd0;
			job.esum   = 8'sd0;
			job.deriv  = 3'sd0;
		end else begin
			job.action = lfps_pkg::ACT_STEER;
			job.err    = err;
			job.esum   = esum_new;
			job.deriv  = deriv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= 1'b0;
			count_q   <= 8'd0;
			esum_q    <= 8'sd0;
			prev_q    <= 2'sd0;
		end else if (push) begin
			if (trig) begin
				latched_q <= 1'b1;
				count_q   <= count_inc;
				// crossing forward restarts the loop; stop keeps it
				if (count_inc < target) begin
					esum_q <= 8'sd0;
					prev_q <= 2'sd0;
				end
			end else begin
				if (!sense[0] && !sense[3]) begin
					latched_q <= 1'b0;
				end
				esum_q <= esum_new;
				prev_q <= err;
			end
		end
	end

	a_esum_range: assert property (@(posedge clk) disable iff (!arst_n)
		esum_q <= 8'sd100 && esum_q >= -8'sd100)
		else $error("integral left its clamp range");

endmodule

>>> rtl/lfps_queue.sv
// ----------------------------------------------------------------------------
// lfps_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module lfps_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lfps_pkg::job_t wr_job,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output lfps_pkg::job_t rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lfps_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push & not_full;
	assign do_pop    = pop & not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count past depth");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("job pushed into a full queue");

endmodule

>>> rtl/lfps_back.sv
// ----------------------------------------------------------------------------
// lfps_back
// Three stage datapath: gain products, speed sums, truncate and clamp (or the
// fixed crossing and stop drives) into the output register.
// ----------------------------------------------------------------------------
module lfps_back (
	input  logic           clk,
	input  logic           arst_n,
	input  lfps_pkg::cfg_t cfg,
	input  logic           job_valid,
	input  lfps_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     action,
	output logic [7:0]     left_drive,
	output logic [7:0]     right_drive,
	output logic [7:0]     crossings_seen,
	output logic [1:0]     line_error
);

	localparam int PID_W = 26;
	localparam int SUM_W = PID_W + 1;
	localparam int Q_W   = SUM_W - 8;

	logic                    v_s1, v_s2, v_s3;
	logic                    adv1, adv2, adv3;
	lfps_pkg::job_t          job_s1, job_s2;
	logic signed [PID_W-1:0] prod_p_s1, prod_i_s1, prod_d_s1;
	logic signed [SUM_W-1:0] lsum_s2, rsum_s2;
	logic signed [PID_W-1:0] pid;
	logic signed [SUM_W-1:0] base;
	logic [1:0]              action_s3;
	logic [7:0]              left_s3, right_s3, cross_s3;
	logic [1:0]              err_s3;

	// truncate toward zero on the divide by 256, add trim, clamp to 0..255
	function automatic logic [7:0] to_drive(logic signed [SUM_W-1:0] sum,
		logic signed [6:0] trim);
		logic signed [Q_W-1:0] q;
		logic signed [Q_W:0]   t;
		q = Q_W'(sum >>> 8) + ((sum[SUM_W-1] && (|sum[7:0])) ? Q_W'(1) : Q_W'(0));
		t = (Q_W+1)'(q) + (Q_W+1)'(trim);
		if (t < 0) begin
			return 8'd0;
		end else if (t > (Q_W+1)'(255)) begin
			return 8'hFF;
		end else begin
			return t[7:0];
		end
	endfunction

	assign adv3 = ~v_s3 | out_ready;
	assign adv2 = ~v_s2 | adv3;
	assign adv1 = ~v_s1 | adv2;
	assign pop  = job_valid & adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= job_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			job_s1    <= job;
			prod_p_s1 <= PID_W'($signed({1'b0, cfg.gain_p})) * PID_W'(job.err);
			prod_i_s1 <= PID_W'($signed({1'b0, cfg.gain_i})) * PID_W'(job.esum);
			prod_d_s1 <= PID_W'($signed({1'b0, cfg.gain_d})) * PID_W'(job.deriv);
		end
	end

	always_comb begin
		pid  = prod_p_s1 + prod_i_s1 + prod_d_s1;
		base = SUM_W'($signed({1'b0, cfg.cruise, 8'h00}));
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			job_s2  <= job_s1;
			lsum_s2 <= base + SUM_W'(pid);
			rsum_s2 <= base - SUM_W'(pid);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			action_s3 <= job_s2.action;
			cross_s3  <= job_s2.crossings;
			err_s3    <= job_s2.err;
			case (job_s2.action)
				lfps_pkg::ACT_STEER: begin
					left_s3  <= to_drive(lsum_s2, cfg.trim);
					right_s3 <= to_drive(rsum_s2, 7'sd0);
				end
				lfps_pkg::ACT_CROSS: begin
					left_s3  <= lfps_pkg::FORWARD_SPEED;
					right_s3 <= lfps_pkg::FORWARD_SPEED;
				end
				default: begin
					left_s3  <= 8'd0;
					right_s3 <= 8'd0;
				end
			endcase
		end
	end

	assign out_valid      = v_s3;
	assign action         = action_s3;
	assign left_drive     = left_s3;
	assign right_drive    = right_s3;
	assign crossings_seen = cross_s3;
	assign line_error     = err_s3;

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && action_s3 == lfps_pkg::ACT_STOP |-> left_s3 == 8'd0 && right_s3 == 8'd0)
		else $error("stop result with nonzero drive");

	a_cross_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && action_s3 == lfps_pkg::ACT_CROSS |->
		left_s3 == lfps_pkg::FORWARD_SPEED && err_s3 == 2'd0)
		else $error("crossing result without forward speed");

endmodule

>>> rtl/line_follow_pid_steering_top.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering_top
// PID steering for a line follower on a differential drive.
//
// Channel  Dir  Transfer               Payload
// s_axis   in   s_tvalid & s_tready    one sample of four line sensors
// m_axis   out  m_tvalid & m_tready    action, both drives, count, error
// cfg      in   cfg_we                 register write, no read-back
//
// One sample in per cycle sustained while m_tready holds; each result follows
// its sample through the queue and the product, sum, clamp stages.
// Crossing count and PID state update in the front end at the transfer, so
// samples never wait on the datapath. s_tready drops only when the queue
// is full; output stalls fill the stages and then the queue.
// Reset clears the count, latch, integral and previous error and loads the
// register defaults.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // sense_left_end, sense_mid_left,
	                                                     // sense_mid_right, sense_right_end
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // action[1:0], left_drive[9:2],
	                                                     // right_drive[17:10],
	                                                     // crossings_seen[25:18],
	                                                     // line_error[27:26]
	input  logic                              cfg_we,
	input  logic [lfps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	lfps_pkg::cfg_t cfg_q;
	lfps_pkg::job_t front_job, back_job;
	logic           push, q_not_full, q_not_empty, pop;
	logic [1:0]     action, line_error;
	logic [7:0]     left_drive, right_drive, crossings_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= lfps_pkg::GAIN_P_RST;
			cfg_q.gain_i <= lfps_pkg::GAIN_I_RST;
			cfg_q.gain_d <= lfps_pkg::GAIN_D_RST;
			cfg_q.cruise <= lfps_pkg::CRUISE_RST;
			cfg_q.trim   <= lfps_pkg::TRIM_RST;
			cfg_q.target <= lfps_pkg::TARGET_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				lfps_pkg::REG_GAIN_P: cfg_q.gain_p <= cfg_wdata;
				lfps_pkg::REG_GAIN_I: cfg_q.gain_i <= cfg_wdata;
				lfps_pkg::REG_GAIN_D: cfg_q.gain_d <= cfg_wdata;
				lfps_pkg::REG_CRUISE: cfg_q.cruise <= cfg_wdata[7:0];
				lfps_pkg::REG_TRIM:   cfg_q.trim   <= $signed(cfg_wdata[6:0]);
				lfps_pkg::REG_TARGET: cfg_q.target <= cfg_wdata[7:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	assign s_tready = q_not_full;

	lfps_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.target  (cfg_q.target),
		.in_valid(s_tvalid),
		.sense   (s_tdata[3:0]),
		.q_ready (q_not_full),
		.push    (push),
		.job     (front_job)
	);

	lfps_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (front_job),
		.not_full (q_not_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.rd_job   (back_job)
	);

	lfps_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (q_not_empty),
		.job           (back_job),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.action        (action),
		.left_drive    (left_drive),
		.right_drive   (right_drive),
		.crossings_seen(crossings_seen),
		.line_error    (line_error)
	);

	assign m_tdata = {4'd0, line_error, crossings_seen, right_drive, left_drive, action};

endmodule
